// File: rtl/bsa_pkg.sv
// Package for the block slot allocator.
// Holds the pool sizes, field widths, command and status codes and the
// sequencer state type; no dependencies.
package bsa_pkg;

  // Pool geometry.
  localparam int MAX_BLOCKS     = 64;
  localparam int PREFILL_BLOCKS = 20;
  localparam int BLOCK_CAPACITY = 4072;
  localparam int ALIGN_SHIFT    = 3;

  // Effective prefill count, clipped to the pool.
  localparam int PREFILL_EFF = (PREFILL_BLOCKS > MAX_BLOCKS) ? MAX_BLOCKS : PREFILL_BLOCKS;

  // Field widths.
  localparam int CMD_W   = 2;
  localparam int SIZE_W  = 16;
  localparam int BLK_W   = 6;
  localparam int STAT_W  = 3;
  localparam int CNT_W   = 7;
  localparam int BYTES_W = 18;
  localparam int MAGIC_W = 8;
  localparam int HELD_W  = 12;

  // Scan unit geometry: one group of eight blocks is examined per cycle.
  localparam int GRP_SIZE = 8;
  localparam int GRP_LW   = 3;
  localparam int GRP_W    = BLK_W - GRP_LW;

  // Constant report fields.
  localparam logic [MAGIC_W-1:0] MARKER_VALUE      = MAGIC_W'(16);
  localparam logic               STRATEGY_BEST_FIT = 1'b1;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 56;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_FREE   = 2'd1,
    CMD_STATS  = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 3'd0,
    ST_ZERO    = 3'd1,
    ST_OOM     = 3'd2,
    ST_BAD     = 3'd3,
    ST_DOUBLE  = 3'd4,
    ST_IGNORED = 3'd5,
    ST_LARGE   = 3'd6
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_SCAN     = 5'b00010,
    S_FREE_RD  = 5'b00100,
    S_FREE_UPD = 5'b01000,
    S_DONE     = 5'b10000
  } state_t;

endpackage

// File: rtl/block_slot_allocator_top.sv
// Block slot allocator: top level with the command sequencer, the free-block
// scan unit, the block-size memory and the result register.
// Depends on bsa_pkg.
//
// Usage:
//   Commands arrive on the in_ stream: in_tuser carries the command (allocate,
//   free, statistics), in_tdata the request size and the block to release.
//   Each command gives exactly one result transfer on the out_ stream, which
//   carries the status, the granted block, both block counts, the allocated
//   byte total and the constant marker and strategy fields.
//   Sequencing: a command that is answered at once goes from accept straight
//   to result loading; a free first passes the memory-read and update states;
//   an allocate first scans from one to eight groups of eight blocks, from the highest created block
//   downward, until it finds a free block or, past the lowest group, creates one or reports OOM.
//   Throughput: one command at a time; in_tready is high only while the
//   sequencer is idle, so the next command can be taken once the result
//   is loaded into the output register.
//   Reset clears the pool: no blocks created, all counts zero, allocator not
//   started. The first allocate or statistics command creates the prefill
//   blocks. If the receiver stalls, the result holds in the output register
//   and the sequencer waits to load the next result until it is taken.
module block_slot_allocator_top
  import bsa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [15:0] request_size, [21:16] release_block, [23:22] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [1:0] command
  input  logic [CMD_W-1:0]      in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [2:0] status, [8:3] granted_block, [15:9] count_allocated,
  // [33:16] bytes_allocated, [40:34] count_free, [48:41] magic_value,
  // [49] strategy_code, [55:50] zero
  output logic [OUT_DATA_W-1:0] out_tdata
);

  // Sequencer and pool state.
  state_t                state_r, state_nxt;
  logic                  started_r, started_nxt;
  logic [CNT_W-1:0]      created_r, created_nxt;
  logic [MAX_BLOCKS-1:0] in_use_r, in_use_nxt;
  logic [CNT_W-1:0]      used_r, used_nxt;
  logic [BYTES_W-1:0]    bytes_r, bytes_nxt;
  logic [CNT_W-1:0]      idle_r, idle_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // Per-command payload registers.
  logic [SIZE_W-1:0]     size_r, size_nxt;
  logic [BLK_W-1:0]      blk_r, blk_nxt;
  logic [GRP_W-1:0]      grp_r, grp_nxt;
  status_t               status_r, status_nxt;
  logic [BLK_W-1:0]      grant_r, grant_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [HELD_W-1:0]     held_rd_r;

  // Block size memory.
  logic [HELD_W-1:0]     held_mem [MAX_BLOCKS];
  logic                  wr_en;
  logic [BLK_W-1:0]      wr_addr;

  // Input field views.
  logic                  in_fire;
  cmd_t                  in_cmd;
  logic [SIZE_W-1:0]     in_size;
  logic [BLK_W-1:0]      in_blk;
  logic [SIZE_W:0]       rounded;
  logic [CNT_W-1:0]      created_eff;
  logic [CNT_W-1:0]      created_m1;

  // Scan unit signals.
  logic [GRP_SIZE-1:0]   cand;
  logic                  hit;
  logic [GRP_LW-1:0]     hit_idx;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign in_cmd     = cmd_t'(in_tuser);
  assign in_size    = in_tdata[SIZE_W-1:0];
  assign in_blk     = in_tdata[SIZE_W +: BLK_W];
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Size rounded up to the alignment unit.
  assign rounded = ({1'b0, in_size} + (SIZE_W+1)'((1 << ALIGN_SHIFT) - 1))
                   & ~(SIZE_W+1)'((1 << ALIGN_SHIFT) - 1);

  // Created count as seen after a possible pool start.
  assign created_eff = started_r ? created_r : CNT_W'(PREFILL_EFF);
  assign created_m1  = created_eff - CNT_W'(1);

  // Scan unit: free, created blocks of the current group, highest one wins.
  always_comb begin
    cand    = '0;
    hit     = 1'b0;
    hit_idx = '0;
    for (int j = 0; j < GRP_SIZE; j++) begin
      cand[j] = !in_use_r[{grp_r, GRP_LW'(j)}]
                && ({1'b0, grp_r, GRP_LW'(j)} < created_r);
    end
    for (int j = 0; j < GRP_SIZE; j++) begin
      if (cand[j]) begin
        hit     = 1'b1;
        hit_idx = GRP_LW'(j);
      end
    end
  end

  // Sequencer next-state logic.
  always_comb begin
    state_nxt     = state_r;
    started_nxt   = started_r;
    created_nxt   = created_r;
    in_use_nxt    = in_use_r;
    used_nxt      = used_r;
    bytes_nxt     = bytes_r;
    idle_nxt      = idle_r;
    out_valid_nxt = out_valid_r;
    size_nxt      = size_r;
    blk_nxt       = blk_r;
    grp_nxt       = grp_r;
    status_nxt    = status_r;
    grant_nxt     = grant_r;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_addr       = '0;

    // The output register empties on a completed transfer.
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          size_nxt  = in_size;
          blk_nxt   = in_blk;
          grant_nxt = '0;
          state_nxt = S_DONE;
          case (in_cmd)
            CMD_ALLOC: begin
              if (!started_r) begin
                started_nxt = 1'b1;
                created_nxt = CNT_W'(PREFILL_EFF);
                idle_nxt    = CNT_W'(PREFILL_EFF);
              end
              if (in_size == '0) begin
                status_nxt = ST_ZERO;
              end else if (rounded > (SIZE_W+1)'(BLOCK_CAPACITY)) begin
                status_nxt = ST_LARGE;
              end else begin
                grp_nxt   = (created_eff == '0) ? '0 : created_m1[BLK_W-1:GRP_LW];
                state_nxt = S_SCAN;
              end
            end
            CMD_FREE: begin
              if (!started_r) begin
                status_nxt = ST_IGNORED;
              end else if ({1'b0, in_blk} >= created_r) begin
                status_nxt = ST_BAD;
              end else if (!in_use_r[in_blk]) begin
                status_nxt = ST_DOUBLE;
              end else begin
                state_nxt = S_FREE_RD;
              end
            end
            CMD_STATS: begin
              if (!started_r) begin
                started_nxt = 1'b1;
                created_nxt = CNT_W'(PREFILL_EFF);
                idle_nxt    = CNT_W'(PREFILL_EFF);
              end
              status_nxt = ST_OK;
            end
            default: begin
              status_nxt = ST_IGNORED;
            end
          endcase
        end
      end

      // One group per cycle, from the top created block downward.
      S_SCAN: begin
        if (hit) begin
          wr_en      = 1'b1;
          wr_addr    = {grp_r, hit_idx};
          in_use_nxt[{grp_r, hit_idx}] = 1'b1;
          used_nxt   = used_r + CNT_W'(1);
          bytes_nxt  = bytes_r + BYTES_W'(size_r);
          idle_nxt   = idle_r - CNT_W'(1);
          grant_nxt  = {grp_r, hit_idx};
          status_nxt = ST_OK;
          state_nxt  = S_DONE;
        end else if (grp_r == '0) begin
          if (created_r >= CNT_W'(MAX_BLOCKS)) begin
            status_nxt = ST_OOM;
          end else begin
            // Create a fresh block; the free count stays as it is.
            wr_en       = 1'b1;
            wr_addr     = created_r[BLK_W-1:0];
            in_use_nxt[created_r[BLK_W-1:0]] = 1'b1;
            created_nxt = created_r + CNT_W'(1);
            used_nxt    = used_r + CNT_W'(1);
            bytes_nxt   = bytes_r + BYTES_W'(size_r);
            grant_nxt   = created_r[BLK_W-1:0];
            status_nxt  = ST_OK;
          end
          state_nxt = S_DONE;
        end else begin
          grp_nxt = grp_r - GRP_W'(1);
        end
      end

      // The held size is read from memory in this state.
      S_FREE_RD: begin
        state_nxt = S_FREE_UPD;
      end

      S_FREE_UPD: begin
        in_use_nxt[blk_r] = 1'b0;
        used_nxt   = used_r - CNT_W'(1);
        bytes_nxt  = bytes_r - BYTES_W'(held_rd_r);
        idle_nxt   = idle_r + CNT_W'(1);
        status_nxt = ST_OK;
        state_nxt  = S_DONE;
      end

      // Load the result once the output register is free.
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {6'b0, STRATEGY_BEST_FIT, MARKER_VALUE, idle_r, bytes_r,
                           used_r, grant_r, status_r};
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      started_r   <= 1'b0;
      created_r   <= '0;
      in_use_r    <= '0;
      used_r      <= '0;
      bytes_r     <= '0;
      idle_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      started_r   <= started_nxt;
      created_r   <= created_nxt;
      in_use_r    <= in_use_nxt;
      used_r      <= used_nxt;
      bytes_r     <= bytes_nxt;
      idle_r      <= idle_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    size_r     <= size_nxt;
    blk_r      <= blk_nxt;
    grp_r      <= grp_nxt;
    status_r   <= status_nxt;
    grant_r    <= grant_nxt;
    out_data_r <= out_data_nxt;
  end

  // Block size memory: written on a grant, read for a free.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      held_mem[wr_addr] <= size_r[HELD_W-1:0];
    end
    if (state_r == S_FREE_RD) begin
      held_rd_r <= held_mem[blk_r];
    end
  end

`ifndef SYNTH
  // Every created block is either allocated or free.
  a_count_balance: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, used_r} + {1'b0, idle_r}) == {1'b0, created_r})
    else $error("allocated and free counts do not add up to created blocks");

  // The allocated count matches the in-use flags.
  a_in_use_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(in_use_r) == 32'(used_r))
    else $error("in-use flags disagree with allocated count");

  // A result is only raised from the result-loading state.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result raised outside the result-loading state");
`endif

endmodule
